@@ design/aef_pkg.sv @@
// Shared types and constants for the ANSI escape filter.
package aef_pkg;

  localparam int SEQ_DEPTH = 32;
  localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);
  localparam int IDX_W     = $clog2(SEQ_DEPTH);

  localparam logic [7:0] CH_ESC       = 8'h1b;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_LBRACKET  = 8'h5b;
  localparam logic [7:0] CH_RBRACKET  = 8'h5d;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] FINAL_LO     = 8'h40;
  localparam logic [7:0] FINAL_HI     = 8'h7e;

  typedef enum logic [5:0] {
    MODE_TEXT    = 6'b000001,
    MODE_ESC     = 6'b000010,
    MODE_CSI     = 6'b000100,
    MODE_OSC     = 6'b001000,
    MODE_OSC_ESC = 6'b010000,
    MODE_DRAIN   = 6'b100000
  } mode_t;

  // Control from the parser to the row of capture cells.
  typedef struct packed {
    logic             load;
    logic             shift;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;
  } chain_ctrl_t;

endpackage

@@ design/aef_cell.sv @@
// One capture cell: holds a byte, loads a new one or takes its neighbor's.
module aef_cell
  import aef_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] din,
  input  logic [7:0] next_in,
  output logic [7:0] dout
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = din;
    end else if (shift) begin
      data_nxt = next_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign dout = data_r;

endmodule

@@ design/aef_chain.sv @@
// Row of capture cells; bytes are written by index and drained toward cell 0.
module aef_chain
  import aef_pkg::*;
(
  input  logic        clk,
  input  chain_ctrl_t ctrl,
  output logic [7:0]  head
);

  logic [7:0] cell_q [SEQ_DEPTH];

  for (genvar i = 0; i < SEQ_DEPTH; i++) begin : g_cell
    logic [7:0] nb;
    if (i < SEQ_DEPTH - 1) begin : g_mid
      assign nb = cell_q[i+1];
    end else begin : g_end
      assign nb = cell_q[i];
    end
    aef_cell u_cell (
      .clk     (clk),
      .load    (ctrl.load && (ctrl.wr_idx == IDX_W'(i))),
      .shift   (ctrl.shift),
      .din     (ctrl.wr_data),
      .next_in (nb),
      .dout    (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

@@ design/ansi_escape_filter.sv @@
// Top level of the ANSI escape filter: parser, capture row and output register.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_ready, in_byte_in
//  out     | output    | out_valid, out_ready, out_byte_out, out_last_of_run
//
// One input item is taken per cycle while no captured sequence is being sent.
// A completed CSI or two-byte escape then drains one byte per cycle from the
// head cell, and the input stays closed until its last byte is sent.
// A stalled output holds its item; the drain and the input wait with it.
// Reset (synchronous, rst_n low) returns to text mode with an empty capture.
module ansi_escape_filter
  import aef_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out,
  output logic       out_last_of_run
);

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  chain_ctrl_t      ctrl;
  logic [7:0]       head;
  logic             out_free;
  logic             accept;
  logic             cap_ok;
  logic             passes;
  logic             is_final;
  logic [7:0]       b;

  assign b        = in_byte_in;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (mode_r != MODE_DRAIN) && out_free;
  assign accept   = in_valid && in_ready;
  assign cap_ok   = count_r < CNT_W'(SEQ_DEPTH);
  assign passes   = (b >= CH_SPACE) || (b == CH_CR) || (b == CH_LF) ||
                    (b == CH_TAB) || (b == CH_BS);
  assign is_final = (b >= FINAL_LO) && (b <= FINAL_HI);

  aef_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .head (head)
  );

  always_comb begin
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    ctrl.load     = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.wr_idx   = count_r[IDX_W-1:0];
    ctrl.wr_data  = b;

    unique case (mode_r)
      MODE_TEXT: begin
        if (accept) begin
          if (b == CH_ESC) begin
            ctrl.load   = 1'b1;
            ctrl.wr_idx = '0;
            count_nxt   = CNT_W'(1);
            ovf_nxt     = 1'b0;
            mode_nxt    = MODE_ESC;
          end else if (passes) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = b;
            out_last_nxt  = 1'b1;
          end
        end
      end
      MODE_ESC: begin
        // Only the leading ESC is held here, so the next slot is always free.
        if (accept) begin
          if (b == CH_LBRACKET) begin
            ctrl.load = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            mode_nxt  = MODE_CSI;
          end else if (b == CH_RBRACKET) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            mode_nxt  = MODE_OSC;
          end else if (b == CH_ESC) begin
            ctrl.load   = 1'b1;
            ctrl.wr_idx = '0;
            count_nxt   = CNT_W'(1);
            ovf_nxt     = 1'b0;
          end else begin
            ctrl.load = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            mode_nxt  = MODE_DRAIN;
          end
        end
      end
      MODE_CSI: begin
        if (accept) begin
          if (cap_ok) begin
            ctrl.load = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (is_final) begin
            if (ovf_r || !cap_ok) begin
              // An overflowed sequence is discarded without output.
              count_nxt = '0;
              ovf_nxt   = 1'b0;
              mode_nxt  = MODE_TEXT;
            end else begin
              mode_nxt = MODE_DRAIN;
            end
          end
        end
      end
      MODE_OSC: begin
        if (accept) begin
          if (b == CH_BEL) begin
            mode_nxt = MODE_TEXT;
          end else if (b == CH_ESC) begin
            mode_nxt = MODE_OSC_ESC;
          end
        end
      end
      MODE_OSC_ESC: begin
        if (accept) begin
          if (b == CH_BACKSLASH) begin
            mode_nxt = MODE_TEXT;
          end else if (b != CH_ESC) begin
            mode_nxt = MODE_OSC;
          end
        end
      end
      MODE_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = head;
          out_last_nxt  = (count_r == CNT_W'(1));
          ctrl.shift    = 1'b1;
          count_nxt     = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            mode_nxt = MODE_TEXT;
          end
        end
      end
      default: begin
        mode_nxt = MODE_TEXT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TEXT;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte_out    = out_byte_r;
  assign out_last_of_run = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SEQ_DEPTH))
    else $error("capture count beyond buffer depth");

  a_drain_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DRAIN) |-> (count_r != '0) && !ovf_r)
    else $error("drain with empty or overflowed capture");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DRAIN && out_free && count_r == CNT_W'(1))
      |=> (mode_r == MODE_TEXT) && out_valid_r && out_last_r)
    else $error("last drained item not marked or mode not back to text");

endmodule
